// File: hdl/mi3_pkg.sv
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// Used by mi3_div_pipe and matrix_inverse_3x3_unit; depends on nothing.
package mi3_pkg;

  // Default element format: Q16.16 in 32 bits
  localparam int MI3_ELEM_WIDTH = 32;
  localparam int MI3_FRAC_BITS  = 16;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_SAT      = 2'd2
  } mi3_status_t;

  // Per-item flags that ride alongside the divider lanes
  typedef struct packed {
    logic [8:0] neg;   // quotient sign per element
    logic [8:0] over;  // quotient is at least 2^ELEM_WIDTH
    logic       zero;  // determinant is zero
  } mi3_side_t;

endpackage

// File: hdl/mi3_div_pipe.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// Shares one divisor pipeline across lanes; depends on mi3_pkg.
module mi3_div_pipe import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = MI3_ELEM_WIDTH,
  parameter int FRAC_BITS  = MI3_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic [ELEM_WIDTH-1:0]                adv,
  input  logic [2*ELEM_WIDTH+2*FRAC_BITS:0]    nmag_in [9],
  input  logic [3*ELEM_WIDTH+3:0]              dmag_in,
  input  mi3_side_t                            side_in,
  output logic [ELEM_WIDTH-1:0]                q_out [9],
  output mi3_side_t                            side_out
);

  localparam int E   = ELEM_WIDTH;
  localparam int NW  = 2*E + 1 + 2*FRAC_BITS;
  localparam int DMW = 3*E + 4;
  localparam int RW  = (NW > DMW + E) ? NW : DMW + E;

  logic [NW-1:0]  rem_r  [E][9];
  logic [E-1:0]   q_r    [E][9];
  logic [DMW-1:0] dmag_r [E];
  mi3_side_t      side_r [E];

  for (genvar s = 0; s < E; s++) begin : g_stage
    logic [NW-1:0]  rem_in [9];
    logic [E-1:0]   q_in   [9];
    logic [DMW-1:0] dm_in;
    mi3_side_t      sd_in;
    logic [NW-1:0]  rem_next [9];
    logic [E-1:0]   q_next   [9];

    // Select the stage input: fresh operands or the previous stage
    if (s == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 9; i++) begin
          rem_in[i] = nmag_in[i];
          q_in[i]   = '0;
        end
        dm_in = dmag_in;
        sd_in = side_in;
      end
    end else begin : g_rest
      always_comb begin
        for (int i = 0; i < 9; i++) begin
          rem_in[i] = rem_r[s-1][i];
          q_in[i]   = q_r[s-1][i];
        end
        dm_in = dmag_r[s-1];
        sd_in = side_r[s-1];
      end
    end

    // Trial subtract of the shifted divisor, settle one quotient bit
    always_comb begin
      logic [RW-1:0] trial;
      logic [RW-1:0] rw;
      trial = RW'(dm_in) << (E - 1 - s);
      for (int i = 0; i < 9; i++) begin
        rw = RW'(rem_in[i]);
        if (rw >= trial) begin
          rem_next[i] = NW'(rw - trial);
          q_next[i]   = q_in[i] | (E'(1) << (E - 1 - s));
        end else begin
          rem_next[i] = rem_in[i];
          q_next[i]   = q_in[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        for (int i = 0; i < 9; i++) begin
          rem_r[s][i] <= rem_next[i];
          q_r[s][i]   <= q_next[i];
        end
        dmag_r[s] <= dm_in;
        side_r[s] <= sd_in;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) q_out[i] = q_r[E-1][i];
  end
  assign side_out = side_r[E-1];

endmodule

// File: hdl/matrix_inverse_3x3_unit.sv
// 3x3 signed fixed-point matrix inverse by the adjugate method.
// Depends on mi3_pkg and mi3_div_pipe.
//
// Usage: present the nine elements of a matrix on in_rRcC with in_valid;
// a transfer happens on a clock edge with in_valid high and in_stall low.
// The inverse comes out on out_rRcC with a status code (ok, singular,
// saturated); a transfer happens with out_valid high and out_stall low.
// A singular matrix gives all-zero elements and the singular status.
// The pipeline has ELEM_WIDTH + 8 stages (40 with 32-bit elements): seven
// for products, cofactors, the determinant, magnitudes and the overflow
// test, one per quotient bit in the divider, and the output register.
// Throughput is one matrix per cycle while out_stall is low. Each stage
// holds while the stage after it is full and held, so a stalled receiver
// backs up the pipeline one stage at a time and empty stages keep filling;
// in_stall rises only when every stage holds an item. Reset empties the
// pipeline; no results are pending after it.
module matrix_inverse_3x3_unit import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = MI3_ELEM_WIDTH,
  parameter int FRAC_BITS  = MI3_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ELEM_WIDTH-1:0] in_r0c0,
  input  logic signed [ELEM_WIDTH-1:0] in_r0c1,
  input  logic signed [ELEM_WIDTH-1:0] in_r0c2,
  input  logic signed [ELEM_WIDTH-1:0] in_r1c0,
  input  logic signed [ELEM_WIDTH-1:0] in_r1c1,
  input  logic signed [ELEM_WIDTH-1:0] in_r1c2,
  input  logic signed [ELEM_WIDTH-1:0] in_r2c0,
  input  logic signed [ELEM_WIDTH-1:0] in_r2c1,
  input  logic signed [ELEM_WIDTH-1:0] in_r2c2,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ELEM_WIDTH-1:0] out_r0c0,
  output logic signed [ELEM_WIDTH-1:0] out_r0c1,
  output logic signed [ELEM_WIDTH-1:0] out_r0c2,
  output logic signed [ELEM_WIDTH-1:0] out_r1c0,
  output logic signed [ELEM_WIDTH-1:0] out_r1c1,
  output logic signed [ELEM_WIDTH-1:0] out_r1c2,
  output logic signed [ELEM_WIDTH-1:0] out_r2c0,
  output logic signed [ELEM_WIDTH-1:0] out_r2c1,
  output logic signed [ELEM_WIDTH-1:0] out_r2c2,
  output logic [1:0]                   status
);

  localparam int E   = ELEM_WIDTH;
  localparam int PW  = 2*E;             // element product
  localparam int AW  = 2*E + 1;         // cofactor
  localparam int LW  = 2*E + 1;         // determinant partial product
  localparam int TW  = 3*E + 2;         // one determinant term
  localparam int DW  = 3*E + 4;         // determinant
  localparam int NW  = AW + 2*FRAC_BITS;
  localparam int RW  = (NW > DW + E) ? NW : DW + E;
  localparam int NS  = E + 8;           // pipeline stages
  localparam int DS  = 7;               // first divider stage

  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  localparam logic [E-1:0] LIM = {1'b1, {(E-1){1'b0}}};

  logic [NS-1:0] valid;
  logic [NS-1:0] adv;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NS-1] = !valid[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) adv[k] = !valid[k] || adv[k+1];
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) valid[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) valid[k] <= valid[k-1];
      end
    end
  end

  logic signed [E-1:0] elem [9];
  assign elem[0] = in_r0c0;
  assign elem[1] = in_r0c1;
  assign elem[2] = in_r0c2;
  assign elem[3] = in_r1c0;
  assign elem[4] = in_r1c1;
  assign elem[5] = in_r1c2;
  assign elem[6] = in_r2c0;
  assign elem[7] = in_r2c1;
  assign elem[8] = in_r2c2;

  // Stage 0: the two products of every cofactor
  logic signed [PW-1:0] pa_c [9];
  logic signed [PW-1:0] pb_c [9];
  logic signed [PW-1:0] pa_r [9];
  logic signed [PW-1:0] pb_r [9];
  logic signed [E-1:0]  row0_s0 [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pa_c[r*3+c] = PW'(elem[NXT1[c]*3+NXT1[r]]) * PW'(elem[NXT2[c]*3+NXT2[r]]);
        pb_c[r*3+c] = PW'(elem[NXT1[c]*3+NXT2[r]]) * PW'(elem[NXT2[c]*3+NXT1[r]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 9; i++) begin
        pa_r[i] <= pa_c[i];
        pb_r[i] <= pb_c[i];
      end
      for (int i = 0; i < 3; i++) row0_s0[i] <= elem[i];
    end
  end

  // Stage 1: cofactors
  logic signed [AW-1:0] adj_s1 [9];
  logic signed [E-1:0]  row0_s1 [3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 9; i++) adj_s1[i] <= AW'(pa_r[i]) - AW'(pb_r[i]);
      for (int i = 0; i < 3; i++) row0_s1[i] <= row0_s0[i];
    end
  end

  // Stage 2: determinant partial products, cofactor split in low and high halves
  logic signed [LW-1:0] lo_s2 [3];
  logic signed [LW-1:0] hi_s2 [3];
  logic signed [AW-1:0] adj_s2 [9];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int k = 0; k < 3; k++) begin
        lo_s2[k] <= LW'(row0_s1[k]) * LW'($signed({1'b0, adj_s1[k*3][E-1:0]}));
        hi_s2[k] <= LW'(row0_s1[k]) * LW'($signed(adj_s1[k*3][AW-1:E]));
      end
      for (int i = 0; i < 9; i++) adj_s2[i] <= adj_s1[i];
    end
  end

  // Stage 3: recombine each determinant term
  logic signed [TW-1:0] term_s3 [3];
  logic signed [AW-1:0] adj_s3 [9];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int k = 0; k < 3; k++) begin
        term_s3[k] <= $signed({{(TW-LW-E){hi_s2[k][LW-1]}}, hi_s2[k], {E{1'b0}}})
                    + TW'(lo_s2[k]);
      end
      for (int i = 0; i < 9; i++) adj_s3[i] <= adj_s2[i];
    end
  end

  // Stage 4: determinant
  logic signed [DW-1:0] det_s4;
  logic signed [AW-1:0] adj_s4 [9];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      det_s4 <= DW'(term_s3[0]) + DW'(term_s3[1]) + DW'(term_s3[2]);
      for (int i = 0; i < 9; i++) adj_s4[i] <= adj_s3[i];
    end
  end

  // Stage 5: determinant magnitude, sign and zero test
  logic [DW-1:0]        dmag_s5;
  logic                 dneg_s5;
  logic                 zero_s5;
  logic signed [AW-1:0] adj_s5 [9];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      dmag_s5 <= det_s4[DW-1] ? DW'(-det_s4) : DW'(det_s4);
      dneg_s5 <= det_s4[DW-1];
      zero_s5 <= (det_s4 == '0);
      for (int i = 0; i < 9; i++) adj_s5[i] <= adj_s4[i];
    end
  end

  // Stage 6: scaled numerator magnitudes, quotient signs, overflow test
  logic [NW-1:0] nmag_c [9];
  logic [NW-1:0] nmag_s6 [9];
  logic [DW-1:0] dmag_s6;
  mi3_side_t     side_c;
  mi3_side_t     side_s6;

  always_comb begin
    logic [AW-1:0] amag;
    for (int i = 0; i < 9; i++) begin
      amag        = adj_s5[i][AW-1] ? AW'(-adj_s5[i]) : AW'(adj_s5[i]);
      nmag_c[i]   = {amag, {(2*FRAC_BITS){1'b0}}};
      side_c.neg[i]  = adj_s5[i][AW-1] ^ dneg_s5;
      side_c.over[i] = RW'(nmag_c[i]) >= (RW'(dmag_s5) << E);
    end
    side_c.zero = zero_s5;
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int i = 0; i < 9; i++) nmag_s6[i] <= nmag_c[i];
      dmag_s6 <= dmag_s5;
      side_s6 <= side_c;
    end
  end

  // Divider stages
  logic [E-1:0] q_div [9];
  mi3_side_t    side_div;

  mi3_div_pipe #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .adv      (adv[DS +: E]),
    .nmag_in  (nmag_s6),
    .dmag_in  (dmag_s6),
    .side_in  (side_s6),
    .q_out    (q_div),
    .side_out (side_div)
  );

  // Output stage: saturate, apply sign, flag singular matrices
  logic [E-1:0]   res_c [9];
  mi3_status_t    status_c;
  logic [E-1:0]   res_r [9];
  mi3_status_t    status_r;

  always_comb begin
    logic         sat;
    logic [E-1:0] qs;
    logic         any_sat;
    any_sat = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (side_div.neg[i]) begin
        sat = side_div.over[i] || (q_div[i] > LIM);
        qs  = sat ? LIM : q_div[i];
        res_c[i] = E'(-qs);
      end else begin
        sat = side_div.over[i] || (q_div[i] > LIM - E'(1));
        qs  = sat ? LIM - E'(1) : q_div[i];
        res_c[i] = qs;
      end
      any_sat = any_sat | sat;
    end
    if (side_div.zero) begin
      for (int i = 0; i < 9; i++) res_c[i] = '0;
      status_c = ST_SINGULAR;
    end else if (any_sat) begin
      status_c = ST_SAT;
    end else begin
      status_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      for (int i = 0; i < 9; i++) res_r[i] <= res_c[i];
      status_r <= status_c;
    end
  end

  assign out_valid = valid[NS-1];
  assign out_r0c0  = res_r[0];
  assign out_r0c1  = res_r[1];
  assign out_r0c2  = res_r[2];
  assign out_r1c0  = res_r[3];
  assign out_r1c1  = res_r[4];
  assign out_r1c2  = res_r[5];
  assign out_r2c0  = res_r[6];
  assign out_r2c1  = res_r[7];
  assign out_r2c2  = res_r[8];
  assign status    = status_r;

endmodule
